>>> hw/rtl/lhis_pkg.sv
`default_nettype none

package lhis_pkg;

    // Word and operand widths
    localparam int FRAC_BITS = 32;
    localparam int POS_W     = 40;   // state and coefficient words
    localparam int STEP_W    = 32;   // step size h, unsigned
    localparam int WIDE_W    = 61;   // saturated product / derivative range
    localparam int DSUM_W    = 62;   // d1 + d2, exact
    localparam int ACC_W     = 64;   // derivative term accumulator
    localparam int MUL_A_W   = 62;
    localparam int MUL_B_W   = 48;
    localparam int DIGIT_W   = MUL_B_W / 2;
    localparam int A_DIGIT_W = MUL_A_W / 2;
    localparam int DPROD_W   = A_DIGIT_W + DIGIT_W + 2;   // one signed digit product
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SHR_W     = PROD_W - FRAC_BITS;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RHO       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_Z    = 3'd6;

    // Reset values
    localparam logic [STEP_W-1:0]       RST_STEP_SIZE = 32'd429497;
    localparam logic signed [POS_W-1:0] RST_SIGMA     = 40'sd42949672960;
    localparam logic signed [POS_W-1:0] RST_RHO       = 40'sd120259084288;
    localparam logic signed [POS_W-1:0] RST_BETA      = 40'sd11453246123;
    localparam logic signed [POS_W-1:0] RST_INIT_X    = 40'sd9019431322;
    localparam logic signed [POS_W-1:0] RST_INIT_Y    = 40'sd6442450944;
    localparam logic signed [POS_W-1:0] RST_INIT_Z    = 40'sd64424509440;

    // Micro-op within one derivative/update phase
    localparam logic [2:0] OP_SIGMA_DYX = 3'd0;  // sigma*(y-x)
    localparam logic [2:0] OP_RHO_X     = 3'd1;  // rho*x - y
    localparam logic [2:0] OP_X_Z       = 3'd2;  // ... - x*z
    localparam logic [2:0] OP_X_Y       = 3'd3;  // x*y
    localparam logic [2:0] OP_BETA_Z    = 3'd4;  // ... - beta*z
    localparam logic [2:0] OP_H_DX      = 3'd5;  // h*dx, update x
    localparam logic [2:0] OP_H_DY      = 3'd6;
    localparam logic [2:0] OP_H_DZ      = 3'd7;

    // Partial product order within one multiply
    localparam logic [1:0] MUL_HH = 2'd0;  // a high digit * b high digit
    localparam logic [1:0] MUL_LH = 2'd1;  // a low digit * b high digit
    localparam logic [1:0] MUL_HL = 2'd2;  // a high digit * b low digit
    localparam logic [1:0] MUL_LL = 2'd3;  // a low digit * b low digit

    // Multiplier control
    typedef struct packed {
        logic start;
        logic shr33;   // shift by FRAC_BITS+1 instead of FRAC_BITS
    } mul_ctrl_t;

    // Clamp to the wide range [-2^60, 2^60-1]
    function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [SHR_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SHR_W-1:WIDE_W-1];
        all_zero = ~|v[SHR_W-1:WIDE_W-1];
        if (all_one || all_zero) begin
            return v[WIDE_W-1:0];
        end else if (v[SHR_W-1]) begin
            return {1'b1, {(WIDE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WIDE_W-1){1'b1}}};
        end
    endfunction

    // Clamp to the 40-bit state range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DSUM_W:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[DSUM_W:POS_W-1];
        all_zero = ~|v[DSUM_W:POS_W-1];
        if (all_one || all_zero) begin
            return v[POS_W-1:0];
        end else if (v[DSUM_W]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lhis_mul.sv
`default_nettype none

// Signed 62x48 multiply as four 32x25 digit products on one multiplier,
// high digits first, then floor shift and saturation.
// done rises together with the registered saturated result.
module lhis_mul import lhis_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mul_ctrl_t                  ctrl,
    input  wire logic signed [MUL_A_W-1:0]  a,
    input  wire logic signed [MUL_B_W-1:0]  b,
    output logic                            done,
    output logic signed [WIDE_W-1:0]        res
);

    logic signed [MUL_A_W-1:0]   a_reg;
    logic signed [MUL_B_W-1:0]   b_reg;
    logic                        shr33_reg;
    logic signed [PROD_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]    acc_next;
    logic [1:0]                  step_reg;
    logic                        run_reg;
    logic                        fin_pend_reg;
    logic                        done_reg;
    logic signed [WIDE_W-1:0]    res_reg;

    logic [1:0]                  step;
    logic signed [MUL_A_W-1:0]   a_src;
    logic signed [MUL_B_W-1:0]   b_src;
    logic signed [A_DIGIT_W:0]   dig_a;
    logic signed [DIGIT_W:0]     dig_b;
    logic signed [DPROD_W-1:0]   prod;
    logic signed [SHR_W-1:0]     shr_val;

    // First digit product uses the live operands, the rest the captured ones
    assign step  = ctrl.start ? MUL_HH : step_reg;
    assign a_src = ctrl.start ? a : a_reg;
    assign b_src = ctrl.start ? b : b_reg;

    // Digit select: high digits signed, low digits unsigned
    always_comb begin
        case (step)
            MUL_HH: begin
                dig_a = $signed({a_src[MUL_A_W-1], a_src[MUL_A_W-1:A_DIGIT_W]});
                dig_b = $signed({b_src[MUL_B_W-1], b_src[MUL_B_W-1:DIGIT_W]});
            end
            MUL_LH: begin
                dig_a = $signed({1'b0, a_src[A_DIGIT_W-1:0]});
                dig_b = $signed({b_src[MUL_B_W-1], b_src[MUL_B_W-1:DIGIT_W]});
            end
            MUL_HL: begin
                dig_a = $signed({a_src[MUL_A_W-1], a_src[MUL_A_W-1:A_DIGIT_W]});
                dig_b = $signed({1'b0, b_src[DIGIT_W-1:0]});
            end
            default: begin
                dig_a = $signed({1'b0, a_src[A_DIGIT_W-1:0]});
                dig_b = $signed({1'b0, b_src[DIGIT_W-1:0]});
            end
        endcase
    end

    assign prod = dig_a * dig_b;

    // a*b_hi built first, then shifted up and the b_lo products added
    always_comb begin
        case (step)
            MUL_HH:  acc_next = PROD_W'(prod);
            MUL_LH:  acc_next = (acc_reg <<< A_DIGIT_W) + PROD_W'(prod);
            MUL_HL:  acc_next = (acc_reg <<< DIGIT_W) + (PROD_W'(prod) <<< A_DIGIT_W);
            default: acc_next = acc_reg + PROD_W'(prod);
        endcase
    end

    // Floor shift of the exact product
    assign shr_val = shr33_reg ? {acc_reg[PROD_W-1], acc_reg[PROD_W-1:FRAC_BITS+1]}
                               : acc_reg[PROD_W-1:FRAC_BITS];

    // Datapath
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            a_reg     <= a;
            b_reg     <= b;
            shr33_reg <= ctrl.shr33;
        end
        if (ctrl.start || run_reg) begin
            acc_reg <= acc_next;
        end
        if (fin_pend_reg) begin
            res_reg <= sat_wide(shr_val);
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b0;
            step_reg     <= MUL_HH;
            fin_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            fin_pend_reg <= run_reg && (step_reg == MUL_LL);
            done_reg     <= fin_pend_reg;
            if (ctrl.start) begin
                run_reg  <= 1'b1;
                step_reg <= MUL_LH;
            end else if (run_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == MUL_LL) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lorenz_heun_integrator_step.sv
`default_nettype none

// Lorenz Heun integrator. The result word (state before the step) appears in the cycle after accept.
// A step runs 16 multiplies in turn on one shared 32x25 digit multiplier; the next word is accepted once
// a step word's multiplies finish (a restart word runs none) and the last output word is taken.
// Reset (synchronous, aresetn low) loads register defaults and the default initial state.
module lorenz_heun_integrator_step import lhis_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_idx,
    input  wire logic [POS_W-1:0]             cfg_wdata,
    // tick input
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_restart,
    // state output
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [POS_W-1:0]           m_out_x,
    output logic signed [POS_W-1:0]           m_out_y,
    output logic signed [POS_W-1:0]           m_out_z
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]       h_reg;
    logic signed [POS_W-1:0] sigma_reg, rho_reg, beta_reg;
    logic signed [POS_W-1:0] init_x_reg, init_y_reg, init_z_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [POS_W-1:0] pred_x_reg, pred_y_reg, pred_z_reg;
    logic signed [DSUM_W-1:0] dv_x_reg, dv_y_reg, dv_z_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [POS_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                    m_valid_reg;
    logic [3:0]              op_reg;

    logic                    s_acc;
    logic                    phase;
    logic [2:0]              op_k;
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [POS_W:0]   dyx;
    logic signed [DSUM_W-1:0] dv_sel;
    logic signed [POS_W-1:0] pos_sel;
    mul_ctrl_t               mctl;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                    mul_done;
    logic signed [WIDE_W-1:0] mul_res;
    logic signed [ACC_W-1:0] acc_diff;
    logic signed [WIDE_W-1:0] dval;
    logic signed [DSUM_W-1:0] dv_new;
    logic signed [POS_W-1:0] upd;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_acc   = s_valid && s_ready;
    assign phase   = op_reg[3];
    assign op_k    = op_reg[2:0];

    // Evaluation point: current state in the predictor phase, predicted point after
    assign px  = phase ? pred_x_reg : pos_x_reg;
    assign py  = phase ? pred_y_reg : pos_y_reg;
    assign pz  = phase ? pred_z_reg : pos_z_reg;
    assign dyx = (POS_W+1)'(py) - (POS_W+1)'(px);

    // Component selection for the update ops
    always_comb begin
        case (op_k)
            OP_H_DX: begin
                dv_sel  = dv_x_reg;
                pos_sel = pos_x_reg;
            end
            OP_H_DY: begin
                dv_sel  = dv_y_reg;
                pos_sel = pos_y_reg;
            end
            default: begin
                dv_sel  = dv_z_reg;
                pos_sel = pos_z_reg;
            end
        endcase
    end

    // Multiplier operands
    always_comb begin
        mctl.start = (state_reg == ST_ISSUE);
        mctl.shr33 = 1'b0;
        case (op_k)
            OP_SIGMA_DYX: begin
                mul_a = MUL_A_W'(sigma_reg);
                mul_b = MUL_B_W'(dyx);
            end
            OP_RHO_X: begin
                mul_a = MUL_A_W'(rho_reg);
                mul_b = MUL_B_W'(px);
            end
            OP_X_Z: begin
                mul_a = MUL_A_W'(px);
                mul_b = MUL_B_W'(pz);
            end
            OP_X_Y: begin
                mul_a = MUL_A_W'(px);
                mul_b = MUL_B_W'(py);
            end
            OP_BETA_Z: begin
                mul_a = MUL_A_W'(beta_reg);
                mul_b = MUL_B_W'(pz);
            end
            default: begin
                mul_a      = dv_sel;
                mul_b      = $signed({{(MUL_B_W-STEP_W){1'b0}}, h_reg});
                mctl.shr33 = phase;
            end
        endcase
    end

    lhis_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mctl),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .res     (mul_res)
    );

    // Writeback arithmetic
    assign acc_diff = acc_reg - ACC_W'(mul_res);
    always_comb begin
        if (op_k == OP_SIGMA_DYX) begin
            dval = mul_res;
        end else begin
            dval = sat_wide(SHR_W'(acc_diff));
        end
    end
    assign upd = sat_pos((DSUM_W+1)'(pos_sel) + (DSUM_W+1)'(mul_res));

    always_comb begin
        case (op_k)
            OP_SIGMA_DYX: dv_new = phase ? dv_x_reg + DSUM_W'(dval) : DSUM_W'(dval);
            OP_X_Z:       dv_new = phase ? dv_y_reg + DSUM_W'(dval) : DSUM_W'(dval);
            default:      dv_new = phase ? dv_z_reg + DSUM_W'(dval) : DSUM_W'(dval);
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && !s_restart) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    state_next = (op_reg == 4'hF) ? ST_IDLE : ST_ISSUE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= 4'd0;
            m_valid_reg <= 1'b0;
            h_reg       <= RST_STEP_SIZE;
            sigma_reg   <= RST_SIGMA;
            rho_reg     <= RST_RHO;
            beta_reg    <= RST_BETA;
            init_x_reg  <= RST_INIT_X;
            init_y_reg  <= RST_INIT_Y;
            init_z_reg  <= RST_INIT_Z;
            pos_x_reg   <= RST_INIT_X;
            pos_y_reg   <= RST_INIT_Y;
            pos_z_reg   <= RST_INIT_Z;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_idx)
                    REG_STEP_SIZE: h_reg      <= cfg_wdata[STEP_W-1:0];
                    REG_SIGMA:     sigma_reg  <= cfg_wdata;
                    REG_RHO:       rho_reg    <= cfg_wdata;
                    REG_BETA:      beta_reg   <= cfg_wdata;
                    REG_INIT_X:    init_x_reg <= cfg_wdata;
                    REG_INIT_Y:    init_y_reg <= cfg_wdata;
                    REG_INIT_Z:    init_z_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // output word handshake
            if (s_acc) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (s_acc) begin
                op_reg <= 4'd0;
                if (s_restart) begin
                    pos_x_reg <= init_x_reg;
                    pos_y_reg <= init_y_reg;
                    pos_z_reg <= init_z_reg;
                end
            end else if (state_reg == ST_WAIT && mul_done) begin
                op_reg <= op_reg + 4'd1;
                if (phase) begin
                    case (op_k)
                        OP_H_DX: pos_x_reg <= upd;
                        OP_H_DY: pos_y_reg <= upd;
                        OP_H_DZ: pos_z_reg <= upd;
                        default: ;
                    endcase
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_x_reg <= pos_x_reg;
            out_y_reg <= pos_y_reg;
            out_z_reg <= pos_z_reg;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            case (op_k)
                OP_SIGMA_DYX: dv_x_reg <= dv_new;
                OP_RHO_X:     acc_reg  <= ACC_W'(mul_res) - ACC_W'(py);
                OP_X_Z:       dv_y_reg <= dv_new;
                OP_X_Y:       acc_reg  <= ACC_W'(mul_res);
                OP_BETA_Z:    dv_z_reg <= dv_new;
                OP_H_DX:      if (!phase) pred_x_reg <= upd;
                OP_H_DY:      if (!phase) pred_y_reg <= upd;
                default:      if (!phase) pred_z_reg <= upd;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;
    assign m_out_z = out_z_reg;

endmodule

`default_nettype wire
